[sv/tss_pkg.sv]
// Package with the shared types, codes and constants of the three-sensor seek steering block.
`timescale 1ns / 1ps

package tss_pkg;

  localparam int unsigned DistW  = 12;
  localparam int unsigned RawW   = 12;
  localparam int unsigned SpeedW = 8;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned InTdataW  = 80;
  localparam int unsigned OutTdataW = 32;

  localparam logic [RawW-1:0]   SeeRawLimit     = 12'd620;
  localparam logic [SpeedW:0]   LostRotateBoost = 9'd20;
  localparam logic [SpeedW-1:0] SpeedMax        = 8'd255;
  localparam logic [CoefW:0]    CoefOne         = 17'd4096;
  localparam logic [CoefW-1:0]  CoefNearNone    = 16'd205;
  localparam logic [CoefW-1:0]  CoefNearMid     = 16'd410;
  localparam logic [CoefW-1:0]  CoefZero        = 16'd0;

  // Rounded division by 51 through a reciprocal: exact for dividends below 2**20.
  localparam int unsigned DivInW   = 20;
  localparam int unsigned RecipW   = 21;
  localparam int unsigned RecipSh  = 26;
  localparam logic [RecipW-1:0] Recip51 = 21'd1315861;
  localparam logic [DivInW-1:0] RoundAdd = 20'd25;

  localparam logic [DistW-1:0]     ResetSeeThreshold    = 12'd640;
  localparam logic [DistW-1:0]     ResetBalanceTol      = 12'd32;
  localparam logic [SpeedW-1:0]    ResetLookRotateSpeed = 8'd110;
  localparam logic [SpeedW-1:0]    ResetCatchSpeed      = 8'd255;
  localparam logic [SpeedW-1:0]    ResetChaseSpeed      = 8'd180;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_LOOK  = 2'd1,
    MODE_CHASE = 2'd2,
    MODE_CATCH = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_STOP   = 2'd0,
    CMD_ROTATE = 2'd1,
    CMD_WALK   = 2'd2,
    CMD_SLIDE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STEER_STRAIGHT = 2'd0,
    STEER_LEFT     = 2'd1,
    STEER_RIGHT    = 2'd2
  } steer_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEE_THRESHOLD = 3'd0,
    CFG_BALANCE_TOL   = 3'd1,
    CFG_LOOK_SPEED    = 3'd2,
    CFG_CATCH_SPEED   = 3'd3,
    CFG_CHASE_SPEED   = 3'd4
  } cfg_idx_e;

  localparam logic TURN_LEFT  = 1'b0;
  localparam logic TURN_RIGHT = 1'b1;

  typedef struct packed {
    logic [RawW-1:0]  right_raw;
    logic [RawW-1:0]  middle_raw;
    logic [RawW-1:0]  left_raw;
    logic [DistW-1:0] right_dist;
    logic [DistW-1:0] middle_dist;
    logic [DistW-1:0] left_dist;
    mode_e            mode;
  } item_t;

  typedef struct packed {
    logic               tgt_seen;
    logic [CoefW-1:0]   steer_coef;
    logic [SpeedW-1:0]  speed;
    logic               turn_dir;
    cmd_e               command;
  } result_t;

  typedef struct packed {
    logic [DistW-1:0]  see_threshold;
    logic [DistW-1:0]  balance_tolerance;
    logic [SpeedW-1:0] look_spd;
    logic [SpeedW-1:0] catch_spd;
    logic [SpeedW-1:0] chase_spd;
  } cfg_t;

  typedef struct packed {
    steer_e last_steer;
    logic   last_turn;
  } steer_state_t;

endpackage

[sv/three_sensor_seek_steering.sv]
// Top level of the three-sensor seek steering block.
// An accepted request is held in the input register until the output is free.
// Throughput: one request per cycle while the output is not stalled, set by the
// single decision stage between the input register and the result register.
// Reset: asynchronous, active low; clears both valid flags, loads the default
// configuration, and sets the steering memory to straight with turn right.
`timescale 1ns / 1ps

module three_sensor_seek_steering import tss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: mode, left_dist, middle_dist, right_dist, left_raw,
  // middle_raw, right_raw, zero fill.
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0: command, turn_dir, speed, steer_coef, tgt_seen, zero fill.
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t         cfg;
  item_t        item_q;
  logic         in_valid_q;
  result_t      res_d, res_q;
  logic         out_valid_q;
  steer_state_t state_q, state_d;
  logic         out_free, advance;

  tss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tss_decide u_decide (
    .item_i  (item_q),
    .cfg_i   (cfg),
    .state_i (state_q),
    .res_o   (res_d),
    .state_o (state_d)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      state_q.last_steer <= STEER_STRAIGHT;
      state_q.last_turn  <= TURN_RIGHT;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW-$bits(result_t)){1'b0}}, res_q};

endmodule

[sv/tss_cfg.sv]
// Configuration register file of the three-sensor seek steering block.
`timescale 1ns / 1ps

module tss_cfg import tss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_SEE_THRESHOLD: cfg_d.see_threshold     = cfg_data_i[DistW-1:0];
        CFG_BALANCE_TOL:   cfg_d.balance_tolerance = cfg_data_i[DistW-1:0];
        CFG_LOOK_SPEED:    cfg_d.look_spd          = cfg_data_i[SpeedW-1:0];
        CFG_CATCH_SPEED:   cfg_d.catch_spd         = cfg_data_i[SpeedW-1:0];
        CFG_CHASE_SPEED:   cfg_d.chase_spd         = cfg_data_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.see_threshold     <= ResetSeeThreshold;
      cfg_q.balance_tolerance <= ResetBalanceTol;
      cfg_q.look_spd          <= ResetLookRotateSpeed;
      cfg_q.catch_spd         <= ResetCatchSpeed;
      cfg_q.chase_spd         <= ResetChaseSpeed;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/tss_decide.sv]
// Decision logic that turns one sensor sample into a motor command and the next steering memory.
`timescale 1ns / 1ps

module tss_decide import tss_pkg::*; (
  input  item_t        item_i,
  input  cfg_t         cfg_i,
  input  steer_state_t state_i,
  output result_t      res_o,
  output steer_state_t state_o
);

  logic                  see_l, see_m, see_r, vis;
  logic [SpeedW-1:0]     drive_spd;
  logic [SpeedW:0]       boosted, rs_wide;
  logic [SpeedW-1:0]     lost_speed;
  steer_e                recall_dir, balance_dir, dir_sel;
  logic [DistW-1:0]      diff;
  logic [DivInW-1:0]     dividend;
  logic [DivInW+RecipW-1:0] prod;
  logic [CoefW:0]        coef_wide;
  logic [DistW:0]        l_tol, r_tol;

  function automatic logic sees(input logic [DistW-1:0] dst, input logic [RawW-1:0] raw,
                                input logic [DistW-1:0] thr);
    sees = (raw > SeeRawLimit) && (dst != '0) && (dst <= thr);
  endfunction

  always_comb begin
    see_l = sees(item_i.left_dist, item_i.left_raw, cfg_i.see_threshold);
    see_m = sees(item_i.middle_dist, item_i.middle_raw, cfg_i.see_threshold);
    see_r = sees(item_i.right_dist, item_i.right_raw, cfg_i.see_threshold);
    vis   = see_l | see_m | see_r;

    drive_spd  = (item_i.mode == MODE_CATCH) ? cfg_i.catch_spd : cfg_i.chase_spd;
    boosted    = {1'b0, drive_spd} + LostRotateBoost;
    rs_wide    = (boosted > {1'b0, cfg_i.look_spd}) ? boosted
                                                    : {1'b0, cfg_i.look_spd};
    lost_speed = rs_wide[SpeedW] ? SpeedMax : rs_wide[SpeedW-1:0];

    if (state_i.last_steer == STEER_STRAIGHT) begin
      recall_dir = state_i.last_turn ? STEER_RIGHT : STEER_LEFT;
    end else if (state_i.last_steer == STEER_LEFT) begin
      recall_dir = STEER_LEFT;
    end else begin
      recall_dir = STEER_RIGHT;
    end

    l_tol = {1'b0, item_i.left_dist} + {1'b0, cfg_i.balance_tolerance};
    r_tol = {1'b0, item_i.right_dist} + {1'b0, cfg_i.balance_tolerance};
    if (l_tol < {1'b0, item_i.right_dist}) begin
      balance_dir = STEER_LEFT;
    end else if (r_tol < {1'b0, item_i.left_dist}) begin
      balance_dir = STEER_RIGHT;
    end else begin
      balance_dir = STEER_STRAIGHT;
    end

    diff = (item_i.left_dist > item_i.right_dist) ? item_i.left_dist - item_i.right_dist
                                                  : item_i.right_dist - item_i.left_dist;
    dividend  = {diff, 8'd0} + RoundAdd;
    prod      = {{RecipW{1'b0}}, dividend} * {{DivInW{1'b0}}, Recip51};
    coef_wide = CoefOne - {{(CoefW+1-(DivInW+RecipW-RecipSh)){1'b0}},
                           prod[DivInW+RecipW-1:RecipSh]};

    res_o.tgt_seen   = vis;
    res_o.command    = CMD_STOP;
    res_o.turn_dir   = TURN_LEFT;
    res_o.speed      = '0;
    res_o.steer_coef = CoefZero;
    dir_sel          = STEER_STRAIGHT;

    if (item_i.mode == MODE_NONE) begin
      dir_sel = STEER_STRAIGHT;
    end else if (item_i.mode == MODE_LOOK || !vis) begin
      res_o.command  = CMD_ROTATE;
      res_o.speed    = (item_i.mode == MODE_LOOK) ? cfg_i.look_spd : lost_speed;
      res_o.turn_dir = (recall_dir == STEER_LEFT) ? TURN_LEFT : TURN_RIGHT;
      dir_sel        = recall_dir;
    end else begin
      res_o.speed = drive_spd;
      if (see_m && !see_l && !see_r) begin
        res_o.command = CMD_WALK;
        dir_sel       = STEER_STRAIGHT;
      end else begin
        res_o.command = CMD_SLIDE;
        if (see_l && see_r) begin
          res_o.steer_coef = coef_wide[CoefW-1:0];
          dir_sel          = balance_dir;
        end else begin
          res_o.steer_coef = see_m ? CoefNearMid : CoefNearNone;
          dir_sel          = see_l ? STEER_LEFT : STEER_RIGHT;
        end
        res_o.turn_dir = (dir_sel == STEER_RIGHT) ? TURN_RIGHT : TURN_LEFT;
      end
    end

    state_o.last_steer = dir_sel;
    if (dir_sel == STEER_LEFT) begin
      state_o.last_turn = TURN_LEFT;
    end else if (dir_sel == STEER_RIGHT) begin
      state_o.last_turn = TURN_RIGHT;
    end else begin
      state_o.last_turn = state_i.last_turn;
    end
  end

endmodule

[sv/tss_checker.sv]
// Port-level checker of the three-sensor seek steering block, bound to the top level.
`timescale 1ns / 1ps

module tss_checker import tss_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  result_t res;
  assign res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_stop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.command == CMD_STOP |->
      res.speed == '0 && res.turn_dir == TURN_LEFT && res.steer_coef == CoefZero)
    else $error("stop command carries motion fields");

  a_coef_only_slide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.command != CMD_SLIDE |-> res.steer_coef == CoefZero)
    else $error("steer coefficient outside slide");

  a_drive_needs_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.command == CMD_WALK || res.command == CMD_SLIDE) |->
      res.tgt_seen)
    else $error("driving toward an unseen target");

  a_walk_straight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.command == CMD_WALK |-> res.turn_dir == TURN_LEFT)
    else $error("walk command with a turn direction");

endmodule

bind three_sensor_seek_steering tss_checker u_tss_checker (.*);
